>>> hdl/circular_wall_bounce_defines.svh
// assertion macros used by the circular_wall_bounce rtl
`ifndef CIRCULAR_WALL_BOUNCE_DEFINES_SVH
`define CIRCULAR_WALL_BOUNCE_DEFINES_SVH

// same-cycle implication
`define CWB_ASSERT_NOW(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("circular_wall_bounce: assertion failed");

// next-cycle implication
`define CWB_ASSERT_NEXT(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("circular_wall_bounce: assertion failed");

`endif

>>> hdl/cwb_pkg.sv
package cwb_pkg;

  localparam int CfgIdxBits = 3;

  typedef enum logic [CfgIdxBits-1:0] {
    RegCenterX     = 3'd0,
    RegCenterY     = 3'd1,
    RegWallRadius  = 3'd2,
    RegPullGain    = 3'd3,
    RegRestitution = 3'd4
  } cfg_reg_e;

  // divider lanes: two reflection quotients, two position corrections
  localparam int DivLanes = 4;
  localparam int LaneRefX = 0;
  localparam int LaneRefY = 1;
  localparam int LaneCorX = 2;
  localparam int LaneCorY = 3;

  localparam int DivQBits = 41;
  localparam int NumBits  = 97;
  localparam int DenBits  = 64;

  localparam logic [15:0] RestitutionReset = 16'd60948;
  // 0.0001 in q32.32
  localparam logic [63:0] EpsQ32 = 64'd429496;
  localparam logic [DivQBits-1:0] DeltaCap = {1'b1, {(DivQBits-1){1'b0}}};

  typedef struct packed {
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] vx;
    logic signed [31:0] vy;
    logic               dx_neg;
    logic               dy_neg;
    logic               hit;
    logic               pos;
  } side_t;

endpackage

>>> hdl/circular_wall_bounce.sv
// Circular wall bounce: takes one body (position, velocity, radius, signed Q16.16) per cycle
// while in_stall_o is low and returns it corrected for a circular world wall, with a restitution
// bounce on outward velocity, a pull toward the center, and a hit flag. Fully pipelined: one
// item per cycle sustained while the output buffer has room. The restoring divider resolves
// one quotient bit per stage over 41 stages, four lanes side by side. A two-entry output buffer
// lets the block keep taking items while a result waits; in_stall_o rises only when both
// entries hold results. Configuration registers are written through the cfg port; the user
// must write them only while no item is in flight, as the block itself does not enforce this.
`include "circular_wall_bounce_defines.svh"

module circular_wall_bounce import cwb_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CfgIdxBits-1:0] cfg_index_i,
  input  logic [31:0]           cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic signed [31:0]    pos_x_i,
  input  logic signed [31:0]    pos_y_i,
  input  logic signed [31:0]    vel_x_i,
  input  logic signed [31:0]    vel_y_i,
  input  logic [30:0]           body_radius_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic signed [31:0]    new_pos_x_o,
  output logic signed [31:0]    new_pos_y_o,
  output logic signed [31:0]    new_vel_x_o,
  output logic signed [31:0]    new_vel_y_o,
  output logic                  wall_hit_o
);

  typedef struct packed {
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] vx;
    logic signed [31:0] vy;
    logic               hit;
  } res_t;

  function automatic logic [31:0] sat32(input logic [43:0] v);
    if (v[43:31] == {13{v[31]}}) begin
      return v[31:0];
    end
    return v[43] ? 32'h8000_0000 : 32'h7fff_ffff;
  endfunction

  // configuration
  logic signed [31:0] center_x_q, center_y_q;
  logic [30:0]        wall_radius_q;
  logic [15:0]        pull_gain_q, restitution_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      center_x_q    <= '0;
      center_y_q    <= '0;
      wall_radius_q <= '0;
      pull_gain_q   <= '0;
      restitution_q <= RestitutionReset;
    end else if (cfg_valid_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        RegCenterX:     center_x_q    <= cfg_data_i;
        RegCenterY:     center_y_q    <= cfg_data_i;
        RegWallRadius:  wall_radius_q <= cfg_data_i[30:0];
        RegPullGain:    pull_gain_q   <= cfg_data_i[15:0];
        RegRestitution: restitution_q <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  // pipeline enable and output buffer control
  logic [1:0] ocnt_q;
  logic       en, push, pop;
  logic       s1_v_q, s2_v_q, s3_v_q, s4_v_q, s5_v_q, s6_v_q, s7_v_q, s8_v_q;
  logic       a_v_q, b_v_q, c_v_q, d_v_q, e_v_q;
  logic [12:0] pipe_v;

  assign en         = (ocnt_q != 2'd2);
  assign in_stall_o = !en;
  assign push       = e_v_q && en;
  assign pop        = (ocnt_q != 2'd0) && !out_stall_i;
  assign pipe_v     = {s1_v_q, s2_v_q, s3_v_q, s4_v_q, s5_v_q, s6_v_q, s7_v_q, s8_v_q,
                       a_v_q, b_v_q, c_v_q, d_v_q, e_v_q};

  // front stages
  side_t              s1_side_q, s2_side_q, s3_side_q, s4_side_q;
  side_t              s5_side_q, s6_side_q, s7_side_q, s8_side_q;
  side_t              s4_side_d;
  logic signed [31:0] s1_dx_q, s1_dy_q, s1_lim_q;
  logic signed [63:0] s2_dxx_q, s2_dyy_q, s2_ll_q, s2_p1_q, s2_p2_q;
  logic [31:0]        s2_adx_q, s2_ady_q, s3_adx_q, s3_ady_q, s4_adx_q, s4_ady_q;
  logic [63:0]        s3_dist_q, s3_lsq_q;
  logic [64:0]        s3_vsum_q;
  logic [63:0]        s4_dist_q, s4_vm_q, s4_over_q;
  logic [63:0]        s5_dist_q, s6_dist_q, s7_dist_q, s8_dist_q;
  logic [63:0]        s5_axl_q, s5_axh_q, s5_ayl_q, s5_ayh_q;
  logic [63:0]        s5_cxl_q, s5_cxh_q, s5_cyl_q, s5_cyh_q;
  logic [95:0]        s6_avx_q, s6_avy_q, s6_cvx_q, s6_cvy_q;
  logic [95:0]        s7_cvx_q, s7_cvy_q, s8_cvx_q, s8_cvy_q;
  logic [48:0]        s7_rx0_q, s7_rx1_q, s7_rx2_q, s7_ry0_q, s7_ry1_q, s7_ry2_q;
  logic [NumBits-1:0] s8_nx_q, s8_ny_q;

  logic [32:0]  dx_diff, dy_diff, lim_diff;
  logic [16:0]  rq;
  logic [112:0] refl_x, refl_y;

  always_comb begin
    dx_diff  = {pos_x_i[31], pos_x_i} - {center_x_q[31], center_x_q};
    dy_diff  = {pos_y_i[31], pos_y_i} - {center_y_q[31], center_y_q};
    lim_diff = {2'b00, wall_radius_q} - {1'b0, body_radius_i, 1'b0};
    // 1 + e in q1.16
    rq       = {1'b1, restitution_q};
    refl_x   = {64'd0, s7_rx0_q} + {32'd0, s7_rx1_q, 32'd0} + {s7_rx2_q, 64'd0};
    refl_y   = {64'd0, s7_ry0_q} + {32'd0, s7_ry1_q, 32'd0} + {s7_ry2_q, 64'd0};
    s4_side_d     = s3_side_q;
    s4_side_d.hit = (s3_dist_q > s3_lsq_q) && (s3_dist_q > EpsQ32);
    s4_side_d.pos = !s3_vsum_q[64] && (s3_vsum_q != '0);
  end

  // back stages
  logic               div_v;
  logic [DivQBits-1:0] div_quo [DivLanes];
  logic [DivLanes-1:0] div_ovf;
  side_t              div_side;
  logic [NumBits-1:0] div_num [DivLanes];

  assign div_num[LaneRefX] = s8_nx_q;
  assign div_num[LaneRefY] = s8_ny_q;
  assign div_num[LaneCorX] = NumBits'(s8_cvx_q);
  assign div_num[LaneCorY] = NumBits'(s8_cvy_q);

  cwb_div_pipe u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s8_v_q),
    .den_i   (s8_dist_q),
    .num_i   (div_num),
    .side_i  (s8_side_q),
    .valid_o (div_v),
    .quot_o  (div_quo),
    .ovf_o   (div_ovf),
    .side_o  (div_side)
  );

  logic [DivQBits-1:0] mx, my;
  logic [31:0]         corr_x, corr_y;

  always_comb begin
    mx = (div_ovf[LaneRefX] || div_quo[LaneRefX] > DeltaCap) ? DeltaCap : div_quo[LaneRefX];
    my = (div_ovf[LaneRefY] || div_quo[LaneRefY] > DeltaCap) ? DeltaCap : div_quo[LaneRefY];
    if (!(div_side.hit && div_side.pos)) begin
      mx = '0;
      my = '0;
    end
    corr_x = div_side.hit ? div_quo[LaneCorX][31:0] : 32'd0;
    corr_y = div_side.hit ? div_quo[LaneCorY][31:0] : 32'd0;
  end

  logic [33:0] a_pxn_q, a_pyn_q, b_pxn_q, b_pyn_q, c_pxn_q, c_pyn_q, d_pxn_q, d_pyn_q;
  logic [42:0] a_vxr_q, a_vyr_q, b_vxr_q, b_vyr_q, c_vxr_q, c_vyr_q, d_vxr_q, d_vyr_q;
  logic        a_hit_q, b_hit_q, c_hit_q, d_hit_q;
  logic [34:0] b_tx_q, b_ty_q, c_atx_q, c_aty_q;
  logic        c_txn_q, c_tyn_q, d_txn_q, d_tyn_q;
  logic [50:0] d_prx_q, d_pry_q;
  res_t        e_res_q;
  logic [43:0] vfx, vfy;

  always_comb begin
    // pull toward the center uses the corrected position
    vfx = d_txn_q ? {d_vxr_q[42], d_vxr_q} - {9'd0, d_prx_q[50:16]}
                  : {d_vxr_q[42], d_vxr_q} + {9'd0, d_prx_q[50:16]};
    vfy = d_tyn_q ? {d_vyr_q[42], d_vyr_q} - {9'd0, d_pry_q[50:16]}
                  : {d_vyr_q[42], d_vyr_q} + {9'd0, d_pry_q[50:16]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
      s3_v_q <= 1'b0;
      s4_v_q <= 1'b0;
      s5_v_q <= 1'b0;
      s6_v_q <= 1'b0;
      s7_v_q <= 1'b0;
      s8_v_q <= 1'b0;
      a_v_q  <= 1'b0;
      b_v_q  <= 1'b0;
      c_v_q  <= 1'b0;
      d_v_q  <= 1'b0;
      e_v_q  <= 1'b0;
    end else if (en) begin
      s1_v_q <= in_valid_i;
      s2_v_q <= s1_v_q;
      s3_v_q <= s2_v_q;
      s4_v_q <= s3_v_q;
      s5_v_q <= s4_v_q;
      s6_v_q <= s5_v_q;
      s7_v_q <= s6_v_q;
      s8_v_q <= s7_v_q;
      a_v_q  <= div_v;
      b_v_q  <= a_v_q;
      c_v_q  <= b_v_q;
      d_v_q  <= c_v_q;
      e_v_q  <= d_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      // offsets and limit; saturation keeps the sign of the raw difference
      s1_side_q <= '{px: pos_x_i, py: pos_y_i, vx: vel_x_i, vy: vel_y_i,
                     dx_neg: dx_diff[32], dy_neg: dy_diff[32], hit: 1'b0, pos: 1'b0};
      s1_dx_q   <= sat32({{11{dx_diff[32]}}, dx_diff});
      s1_dy_q   <= sat32({{11{dy_diff[32]}}, dy_diff});
      s1_lim_q  <= sat32({{11{lim_diff[32]}}, lim_diff});

      // squares and velocity dot terms
      s2_side_q <= s1_side_q;
      s2_dxx_q <= s1_dx_q * s1_dx_q;
      s2_dyy_q <= s1_dy_q * s1_dy_q;
      s2_ll_q  <= s1_lim_q * s1_lim_q;
      s2_p1_q  <= s1_side_q.vx * s1_dx_q;
      s2_p2_q  <= s1_side_q.vy * s1_dy_q;
      s2_adx_q <= s1_dx_q[31] ? ~s1_dx_q + 32'd1 : s1_dx_q;
      s2_ady_q <= s1_dy_q[31] ? ~s1_dy_q + 32'd1 : s1_dy_q;

      s3_side_q <= s2_side_q;
      s3_dist_q <= s2_dxx_q + s2_dyy_q;
      s3_lsq_q  <= s2_ll_q;
      s3_vsum_q <= {s2_p1_q[63], s2_p1_q} + {s2_p2_q[63], s2_p2_q};
      s3_adx_q  <= s2_adx_q;
      s3_ady_q  <= s2_ady_q;

      s4_side_q     <= s4_side_d;
      s4_vm_q       <= (!s3_vsum_q[64] && (s3_vsum_q != '0)) ? s3_vsum_q[63:0] : 64'd0;
      s4_over_q     <= s3_dist_q - s3_lsq_q;
      s4_dist_q     <= s3_dist_q;
      s4_adx_q      <= s3_adx_q;
      s4_ady_q      <= s3_ady_q;

      // 32x64 products as two halves
      s5_side_q <= s4_side_q;
      s5_dist_q <= s4_dist_q;
      s5_axl_q  <= s4_adx_q * s4_vm_q[31:0];
      s5_axh_q  <= s4_adx_q * s4_vm_q[63:32];
      s5_ayl_q  <= s4_ady_q * s4_vm_q[31:0];
      s5_ayh_q  <= s4_ady_q * s4_vm_q[63:32];
      s5_cxl_q  <= s4_adx_q * s4_over_q[31:0];
      s5_cxh_q  <= s4_adx_q * s4_over_q[63:32];
      s5_cyl_q  <= s4_ady_q * s4_over_q[31:0];
      s5_cyh_q  <= s4_ady_q * s4_over_q[63:32];

      s6_side_q <= s5_side_q;
      s6_dist_q <= s5_dist_q;
      s6_avx_q  <= {32'd0, s5_axl_q} + {s5_axh_q, 32'd0};
      s6_avy_q  <= {32'd0, s5_ayl_q} + {s5_ayh_q, 32'd0};
      s6_cvx_q  <= {32'd0, s5_cxl_q} + {s5_cxh_q, 32'd0};
      s6_cvy_q  <= {32'd0, s5_cyl_q} + {s5_cyh_q, 32'd0};

      // scale by 1 + e in three slices
      s7_side_q <= s6_side_q;
      s7_dist_q <= s6_dist_q;
      s7_cvx_q  <= s6_cvx_q;
      s7_cvy_q  <= s6_cvy_q;
      s7_rx0_q  <= s6_avx_q[31:0] * rq;
      s7_rx1_q  <= s6_avx_q[63:32] * rq;
      s7_rx2_q  <= s6_avx_q[95:64] * rq;
      s7_ry0_q  <= s6_avy_q[31:0] * rq;
      s7_ry1_q  <= s6_avy_q[63:32] * rq;
      s7_ry2_q  <= s6_avy_q[95:64] * rq;

      // dividing by dist_sq * 2^16 equals dropping 16 bits then dividing by dist_sq
      s8_side_q <= s7_side_q;
      s8_dist_q <= s7_dist_q;
      s8_cvx_q  <= s7_cvx_q;
      s8_cvy_q  <= s7_cvy_q;
      s8_nx_q   <= refl_x[112:16];
      s8_ny_q   <= refl_y[112:16];

      // apply reflection and correction against the sign of the offset
      a_hit_q <= div_side.hit;
      a_pxn_q <= div_side.dx_neg ? {{2{div_side.px[31]}}, div_side.px} + {2'd0, corr_x}
                                 : {{2{div_side.px[31]}}, div_side.px} - {2'd0, corr_x};
      a_pyn_q <= div_side.dy_neg ? {{2{div_side.py[31]}}, div_side.py} + {2'd0, corr_y}
                                 : {{2{div_side.py[31]}}, div_side.py} - {2'd0, corr_y};
      a_vxr_q <= div_side.dx_neg ? {{11{div_side.vx[31]}}, div_side.vx} + {2'd0, mx}
                                 : {{11{div_side.vx[31]}}, div_side.vx} - {2'd0, mx};
      a_vyr_q <= div_side.dy_neg ? {{11{div_side.vy[31]}}, div_side.vy} + {2'd0, my}
                                 : {{11{div_side.vy[31]}}, div_side.vy} - {2'd0, my};

      b_hit_q <= a_hit_q;
      b_pxn_q <= a_pxn_q;
      b_pyn_q <= a_pyn_q;
      b_vxr_q <= a_vxr_q;
      b_vyr_q <= a_vyr_q;
      b_tx_q  <= {{3{center_x_q[31]}}, center_x_q} - {a_pxn_q[33], a_pxn_q};
      b_ty_q  <= {{3{center_y_q[31]}}, center_y_q} - {a_pyn_q[33], a_pyn_q};

      c_hit_q <= b_hit_q;
      c_pxn_q <= b_pxn_q;
      c_pyn_q <= b_pyn_q;
      c_vxr_q <= b_vxr_q;
      c_vyr_q <= b_vyr_q;
      c_txn_q <= b_tx_q[34];
      c_tyn_q <= b_ty_q[34];
      c_atx_q <= b_tx_q[34] ? ~b_tx_q + 35'd1 : b_tx_q;
      c_aty_q <= b_ty_q[34] ? ~b_ty_q + 35'd1 : b_ty_q;

      d_hit_q <= c_hit_q;
      d_pxn_q <= c_pxn_q;
      d_pyn_q <= c_pyn_q;
      d_vxr_q <= c_vxr_q;
      d_vyr_q <= c_vyr_q;
      d_txn_q <= c_txn_q;
      d_tyn_q <= c_tyn_q;
      d_prx_q <= c_atx_q * pull_gain_q;
      d_pry_q <= c_aty_q * pull_gain_q;

      e_res_q <= '{px: sat32({{10{d_pxn_q[33]}}, d_pxn_q}),
                   py: sat32({{10{d_pyn_q[33]}}, d_pyn_q}),
                   vx: sat32(vfx),
                   vy: sat32(vfy),
                   hit: d_hit_q};
    end
  end

  // two-entry output buffer
  res_t hd_q, sk_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ocnt_q <= 2'd0;
    end else begin
      ocnt_q <= 2'(ocnt_q + {1'b0, push} - {1'b0, pop});
    end
  end

  always_ff @(posedge clk_i) begin
    if (push && (ocnt_q == 2'd0 || (ocnt_q == 2'd1 && pop))) begin
      hd_q <= e_res_q;
    end else if (pop && ocnt_q == 2'd2) begin
      hd_q <= sk_q;
    end
    if (push && ocnt_q == 2'd1 && !pop) begin
      sk_q <= e_res_q;
    end
  end

  assign out_valid_o = (ocnt_q != 2'd0);
  assign new_pos_x_o = hd_q.px;
  assign new_pos_y_o = hd_q.py;
  assign new_vel_x_o = hd_q.vx;
  assign new_vel_y_o = hd_q.vy;
  assign wall_hit_o  = hd_q.hit;

  `CWB_ASSERT_NEXT(a_pipe_frozen, clk_i, rst_ni, !en, $stable(pipe_v))
  `CWB_ASSERT_NEXT(a_push_lands, clk_i, rst_ni, push, out_valid_o)
  `CWB_ASSERT_NOW(a_corr_no_ovf, clk_i, rst_ni, div_v && div_side.hit, !(div_ovf[LaneCorX] || div_ovf[LaneCorY]))

endmodule

>>> hdl/cwb_div_pipe.sv
module cwb_div_pipe import cwb_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                valid_i,
  input  logic [DenBits-1:0]  den_i,
  input  logic [NumBits-1:0]  num_i [DivLanes],
  input  side_t               side_i,
  output logic                valid_o,
  output logic [DivQBits-1:0] quot_o [DivLanes],
  output logic [DivLanes-1:0] ovf_o,
  output side_t               side_o
);

  // stage 0 loads the top numerator bits, stages 1..DivQBits resolve one quotient bit each
  logic [DivQBits:0]   v_q;
  logic [DenBits-1:0]  den_q [DivQBits+1];
  side_t               side_q [DivQBits+1];
  logic [DivLanes-1:0] ovf_q [DivQBits+1];
  logic [DenBits-1:0]  rem_q [DivQBits+1][DivLanes];
  logic [DivQBits-1:0] nlo_q [DivQBits+1][DivLanes];
  logic [DivQBits-1:0] quo_q [DivQBits+1][DivLanes];

  logic [DenBits-1:0]  rem_d [DivQBits][DivLanes];
  logic [DivQBits-1:0] nlo_d [DivQBits][DivLanes];
  logic [DivQBits-1:0] quo_d [DivQBits][DivLanes];

  always_comb begin
    logic [DenBits:0] trial;
    logic             ge;
    for (int k = 0; k < DivQBits; k++) begin
      for (int l = 0; l < DivLanes; l++) begin
        trial       = {rem_q[k][l], nlo_q[k][l][DivQBits-1]};
        ge          = trial >= {1'b0, den_q[k]};
        rem_d[k][l] = ge ? DenBits'(trial - {1'b0, den_q[k]}) : trial[DenBits-1:0];
        nlo_d[k][l] = {nlo_q[k][l][DivQBits-2:0], 1'b0};
        quo_d[k][l] = {quo_q[k][l][DivQBits-2:0], ge};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[DivQBits-1:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      den_q[0]  <= den_i;
      side_q[0] <= side_i;
      for (int l = 0; l < DivLanes; l++) begin
        rem_q[0][l] <= DenBits'(num_i[l][NumBits-1:DivQBits]);
        nlo_q[0][l] <= num_i[l][DivQBits-1:0];
        quo_q[0][l] <= '0;
        // quotient would not fit the lane width
        ovf_q[0][l] <= DenBits'(num_i[l][NumBits-1:DivQBits]) >= den_i;
      end
      for (int k = 1; k <= DivQBits; k++) begin
        den_q[k]  <= den_q[k-1];
        side_q[k] <= side_q[k-1];
        ovf_q[k]  <= ovf_q[k-1];
        for (int l = 0; l < DivLanes; l++) begin
          rem_q[k][l] <= rem_d[k-1][l];
          nlo_q[k][l] <= nlo_d[k-1][l];
          quo_q[k][l] <= quo_d[k-1][l];
        end
      end
    end
  end

  assign valid_o = v_q[DivQBits];
  assign quot_o  = quo_q[DivQBits];
  assign ovf_o   = ovf_q[DivQBits];
  assign side_o  = side_q[DivQBits];

endmodule
